// ===== rtl/p2g_pkg.sv =====
// Shared types, codes and constants for the particle-to-grid velocity splat.
`default_nettype none
package p2g_pkg;

    // Default grid cell counts per axis
    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;

    // Node coordinate width (grid up to 64 cells, face grid up to 65 nodes)
    localparam int CW = 7;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0] HALF_Q16 = 16'h8000;

    // Accumulator widths
    localparam int VW = 48;
    localparam int WW = 32;

    // Divider widths
    localparam int DIVN = 64;
    localparam int DIVD = 32;

    // Multiplier operand widths
    localparam int MAW = 34;
    localparam int MBW = 33;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [31:0] particle_velocity;
        logic [4:0]         node_i;
        logic [4:0]         node_j;
        logic [4:0]         node_k;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] node_velocity;
        logic               weight_was_zero;
        logic               done_res;
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_CORNER,
        S_MUL2,
        S_MUL3,
        S_UPD,
        S_RD_ADDR,
        S_RD_DATA,
        S_DIV
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/p2g_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module p2g_mul
    import p2g_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic signed [MAW-1:0]        i_a,
    input  wire logic signed [MBW-1:0]        i_b,
    output logic signed [MAW+MBW-1:0]         o_p
);

    logic signed [MAW+MBW-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== rtl/p2g_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module p2g_div
    import p2g_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [DIVN-1:0] i_dividend,
    input  wire logic [DIVD-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIVN-1:0]      o_quotient
);

    localparam int CNTW = $clog2(DIVN + 1);

    logic            r_run, n_run;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DIVD:0]   r_rem, n_rem;
    logic [DIVN-1:0] r_quo, n_quo;
    logic [DIVD-1:0] r_dvs, n_dvs;
    logic [DIVD:0]   rem_sh;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        rem_sh = {r_rem[DIVD-1:0], r_quo[DIVN-1]};
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = CNTW'(DIVN);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_run) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sh - {1'b0, r_dvs};
                n_quo = {r_quo[DIVN-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[DIVN-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control under reset, advance the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/particle_to_grid_velocity_splat.sv =====
// Top level: sequencer, node memory and configuration port of the velocity splat.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------------------
//  command  | start, busy, i_cmd                        | beat taken when start && !busy
//  result   | o_valid, o_res                            | one-cycle strobe, no stall
//  config   | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// Clear: one node per cycle through the single memory write port.
// Splat: a setup step, then for each in-range corner the single multiplier is used
//   three times before the read-modify-write; a skipped corner just advances, and
//   the result follows the last corner.
// Read: address and data steps, then the bit-serial divider when the weight is nonzero.
// After reset the block sweeps every node, zeroing memory with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none
module particle_to_grid_velocity_splat
    import p2g_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_cmd        i_cmd,
    output logic             o_valid,
    output t_res             o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NODES = (GRID_X + 1) * (GRID_Y + 1) * (GRID_Z + 1);
    localparam int AW    = $clog2(NODES);
    localparam int ST_I  = (GRID_Y + 1) * (GRID_Z + 1);
    localparam int ST_J  = GRID_Z + 1;
    localparam int MW    = VW + WW;

    // Configuration register
    logic [1:0] r_axis;
    logic [1:0] axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AX_X;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_axis <= pwdata[1:0];
        end
    end

    assign prdata = {30'b0, r_axis};
    assign pready = 1'b1;
    assign axis   = (r_axis == AX_X || r_axis == AX_Y) ? r_axis : AX_Z;

    // Face grid sizes for the selected axis
    logic [9:0] sz_x, sz_y, sz_z;
    assign sz_x = 10'(GRID_X) + {9'b0, axis == AX_X};
    assign sz_y = 10'(GRID_Y) + {9'b0, axis == AX_Y};
    assign sz_z = 10'(GRID_Z) + {9'b0, axis == AX_Z};

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [AW-1:0]     r_clr_cnt;
    logic              r_clr_res;
    logic [2:0]        r_corner;
    logic signed [8:0] r_base [3];
    logic [15:0]       r_frac [3];
    logic [AW-1:0]     r_addr;
    logic [MW-1:0]     r_rdata;
    logic [16:0]       r_w;
    logic              r_neg;
    logic              r_valid;
    t_res              r_res;

    // Shared multiplier
    logic signed [MAW-1:0]     mul_a;
    logic signed [MBW-1:0]     mul_b;
    logic signed [MAW+MBW-1:0] prod;

    p2g_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Divider for the normalized read
    logic              div_start;
    logic              div_done;
    logic [DIVN-1:0]   div_q;
    logic [VW-1:0]     rd_mag;

    p2g_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({rd_mag, 16'b0}),
        .i_divisor  (r_rdata[WW-1:0]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Corner coordinates, range check and factors
    logic signed [9:0] cn_x, cn_y, cn_z;
    logic              cn_in;
    logic [16:0]       fac_x, fac_y, fac_z;
    logic [AW-1:0]     cn_idx, rd_idx;
    logic              rd_in;

    assign cn_x  = {r_base[0][8], r_base[0]} + {9'b0, r_corner[2]};
    assign cn_y  = {r_base[1][8], r_base[1]} + {9'b0, r_corner[1]};
    assign cn_z  = {r_base[2][8], r_base[2]} + {9'b0, r_corner[0]};
    assign cn_in = !cn_x[9] && !cn_y[9] && !cn_z[9]
                   && (cn_x < sz_x) && (cn_y < sz_y) && (cn_z < sz_z);
    assign fac_x = r_corner[2] ? {1'b0, r_frac[0]} : ONE_Q16 - {1'b0, r_frac[0]};
    assign fac_y = r_corner[1] ? {1'b0, r_frac[1]} : ONE_Q16 - {1'b0, r_frac[1]};
    assign fac_z = r_corner[0] ? {1'b0, r_frac[2]} : ONE_Q16 - {1'b0, r_frac[2]};

    assign cn_idx = AW'(cn_x[CW-1:0]) * AW'(ST_I) + AW'(cn_y[CW-1:0]) * AW'(ST_J)
                    + AW'(cn_z[CW-1:0]);
    assign rd_idx = AW'(r_cmd.node_i) * AW'(ST_I) + AW'(r_cmd.node_j) * AW'(ST_J)
                    + AW'(r_cmd.node_k);
    assign rd_in  = ({5'b0, r_cmd.node_i} < sz_x) && ({5'b0, r_cmd.node_j} < sz_y)
                    && ({5'b0, r_cmd.node_k} < sz_z);

    // Accumulator update
    logic signed [VW-1:0] old_v;
    logic [WW-1:0]        old_w;
    logic [MAW+MBW-1:0]   prod_rnd;
    logic signed [32:0]   contrib;
    logic signed [VW:0]   v_sum;
    logic [WW:0]          w_sum;
    logic [VW-1:0]        new_v;
    logic [WW-1:0]        new_w;
    logic [16:0]          w_rnd;

    assign old_v    = r_rdata[MW-1:WW];
    assign old_w    = r_rdata[WW-1:0];
    assign prod_rnd = prod + (MAW + MBW)'(HALF_Q16);
    assign contrib  = prod_rnd[48:16];
    assign v_sum    = {old_v[VW-1], old_v} + (VW + 1)'(contrib);
    assign new_v    = (v_sum[VW] != v_sum[VW-1])
                      ? {v_sum[VW], {(VW - 1){!v_sum[VW]}}} : v_sum[VW-1:0];
    assign w_sum    = {1'b0, old_w} + {16'b0, r_w};
    assign new_w    = w_sum[WW] ? '1 : w_sum[WW-1:0];
    // round half up, drop 32 fraction bits
    assign w_rnd    = 17'((prod + (MAW + MBW)'(33'h080000000)) >>> 32);

    // Read result forms
    logic [31:0] sat_raw;
    logic [31:0] div_val;
    logic        q_big;

    assign rd_mag  = old_v[VW-1] ? VW'(-old_v) : old_v;
    assign sat_raw = (old_v[VW-1:31] == '0 || old_v[VW-1:31] == '1)
                     ? old_v[31:0] : (old_v[VW-1] ? 32'h80000000 : 32'h7FFFFFFF);
    assign q_big   = |div_q[DIVN-1:31];
    assign div_val = q_big ? (r_neg ? 32'h80000000 : 32'h7FFFFFFF)
                           : (r_neg ? -div_q[31:0] : div_q[31:0]);

    // Memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem [NODES];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Next state, memory controls and finished results
    logic fin;
    t_res fin_res;

    always_comb begin
        n_state   = r_state;
        fin       = 1'b0;
        fin_res   = '0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {new_v, new_w};
        mem_raddr = cn_idx;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = '0;
                if (r_clr_cnt == AW'(NODES - 1)) begin
                    n_state          = S_IDLE;
                    fin              = r_clr_res;
                    fin_res.done_res = 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.operation)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_SPLAT: n_state = S_SETUP;
                        OP_READ:  n_state = S_RD_ADDR;
                        default:  fin = 1'b1;
                    endcase
                end
            end
            S_SETUP: begin
                n_state = S_CORNER;
            end
            S_CORNER: begin
                mul_a = MAW'(fac_x);
                mul_b = MBW'(fac_y);
                if (cn_in) begin
                    n_state = S_MUL2;
                end else if (r_corner == 3'd7) begin
                    n_state          = S_IDLE;
                    fin              = 1'b1;
                    fin_res.done_res = 1'b1;
                end
            end
            S_MUL2: begin
                mul_a   = prod[MAW-1:0];
                mul_b   = MBW'(fac_z);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                mul_a   = MAW'(w_rnd);
                mul_b   = MBW'(r_cmd.particle_velocity);
                n_state = S_UPD;
            end
            S_UPD: begin
                mem_we = 1'b1;
                if (r_corner == 3'd7) begin
                    n_state          = S_IDLE;
                    fin              = 1'b1;
                    fin_res.done_res = 1'b1;
                end else begin
                    n_state = S_CORNER;
                end
            end
            S_RD_ADDR: begin
                mem_raddr = rd_idx;
                if (rd_in) begin
                    n_state = S_RD_DATA;
                end else begin
                    n_state                 = S_IDLE;
                    fin                     = 1'b1;
                    fin_res.weight_was_zero = 1'b1;
                    fin_res.done_res        = 1'b1;
                end
            end
            S_RD_DATA: begin
                if (old_w == '0) begin
                    n_state                 = S_IDLE;
                    fin                     = 1'b1;
                    fin_res.node_velocity   = sat_raw;
                    fin_res.weight_was_zero = 1'b1;
                    fin_res.done_res        = 1'b1;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state               = S_IDLE;
                    fin                   = 1'b1;
                    fin_res.node_velocity = div_val;
                    fin_res.done_res      = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, sweep counter, corner counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_clr_res <= 1'b0;
            r_corner  <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= fin;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end else begin
                r_clr_cnt <= '0;
            end
            if (r_state == S_IDLE && start) begin
                r_clr_res <= 1'b1;
            end
            if (r_state == S_SETUP) begin
                r_corner <= '0;
            end else if ((r_state == S_CORNER && !cn_in) || r_state == S_UPD) begin
                r_corner <= r_corner + 1'b1;
            end
        end
    end

    // Payload registers: command capture, base and fraction, address, weight, read sign, result
    logic signed [24:0] p_sh [3];
    always_comb begin
        p_sh[0] = {r_cmd.pos_x[23], r_cmd.pos_x}
                  - ((axis == AX_X) ? 25'sd0 : 25'(HALF_Q16));
        p_sh[1] = {r_cmd.pos_y[23], r_cmd.pos_y}
                  - ((axis == AX_Y) ? 25'sd0 : 25'(HALF_Q16));
        p_sh[2] = {r_cmd.pos_z[23], r_cmd.pos_z}
                  - ((axis == AX_Z) ? 25'sd0 : 25'(HALF_Q16));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_SETUP) begin
            for (int d = 0; d < 3; d++) begin
                r_base[d] <= p_sh[d][24:16];
                r_frac[d] <= p_sh[d][15:0];
            end
        end
        if (r_state == S_CORNER) begin
            r_addr <= cn_idx;
        end
        if (r_state == S_MUL3) begin
            r_w <= w_rnd;
        end
        if (r_state == S_RD_DATA) begin
            r_neg <= old_v[VW-1];
        end
        r_res <= fin_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== tb/tb_particle_to_grid_velocity_splat.sv =====
// Self-checking testbench for the particle-to-grid velocity splat block.
`timescale 1ns / 1ps
module tb_particle_to_grid_velocity_splat;
    import p2g_pkg::*;

    localparam int GX = 16;
    localparam int GY = 16;
    localparam int GZ = 16;
    localparam int NODES = (GX + 1) * (GY + 1) * (GZ + 1);
    localparam longint VMAX = 64'sd140737488355327;
    localparam longint VMIN = -64'sd140737488355328;
    localparam logic [2:0] ADDR_AXIS = 3'd0;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        o_valid;
    t_res        o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    particle_to_grid_velocity_splat uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_valid(o_valid), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the node accumulators and axis register
    longint      vel_acc [NODES];
    int unsigned wgt_acc [NODES];
    logic [1:0]  axis_reg;

    t_cmd cmd_queue [$];
    t_res node_result_queue [$];
    int   errors = 0;
    bit   beat_taken = 0;
    bit   quiet = 0;
    int   gap = 0;

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Apply one command to the shadow grid and return its result
    function automatic t_res grid_step(input t_cmd c);
        t_res        r;
        int          ax, d, ci, cj, ck, ni, nj, nk, idx;
        int          p, f;
        int          base [3];
        int          sz [3];
        longint      fac [3][2];
        longint      w, contrib, vs, vel, s;
        longint unsigned ws, mag, q;
        int          pos [3];
        r = '0;
        ax = (axis_reg >= 2) ? 2 : int'(axis_reg);
        for (d = 0; d < 3; d++) sz[d] = 16 + ((d == ax) ? 1 : 0);
        case (c.operation)
            OP_CLEAR: begin
                for (idx = 0; idx < NODES; idx++) begin
                    vel_acc[idx] = 0;
                    wgt_acc[idx] = 0;
                end
                r.done_res = 1'b1;
            end
            OP_SPLAT: begin
                pos[0] = c.pos_x;
                pos[1] = c.pos_y;
                pos[2] = c.pos_z;
                vel = c.particle_velocity;
                for (d = 0; d < 3; d++) begin
                    p = pos[d] - ((d == ax) ? 0 : 32768);
                    f = p & 32'hFFFF;
                    base[d] = p >>> 16;
                    fac[d][0] = 65536 - f;
                    fac[d][1] = f;
                end
                for (d = 0; d < 8; d++) begin
                    ci = (d >> 2) & 1;
                    cj = (d >> 1) & 1;
                    ck = d & 1;
                    ni = base[0] + ci;
                    nj = base[1] + cj;
                    nk = base[2] + ck;
                    if (ni < 0 || ni >= sz[0] || nj < 0 || nj >= sz[1] ||
                        nk < 0 || nk >= sz[2])
                        continue;
                    idx = (ni * (GY + 1) + nj) * (GZ + 1) + nk;
                    w = (fac[0][ci] * fac[1][cj] * fac[2][ck] + 64'sd2147483648) >>> 32;
                    contrib = (w * vel + 32768) >>> 16;
                    vs = vel_acc[idx] + contrib;
                    if (vs > VMAX) vs = VMAX;
                    if (vs < VMIN) vs = VMIN;
                    vel_acc[idx] = vs;
                    ws = longint'(wgt_acc[idx]) + w;
                    wgt_acc[idx] = (ws > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ws[31:0];
                end
                r.done_res = 1'b1;
            end
            OP_READ: begin
                r.done_res = 1'b1;
                if (c.node_i >= sz[0] || c.node_j >= sz[1] || c.node_k >= sz[2]) begin
                    r.weight_was_zero = 1'b1;
                end else begin
                    idx = (int'(c.node_i) * (GY + 1) + int'(c.node_j)) * (GZ + 1)
                          + int'(c.node_k);
                    s = vel_acc[idx];
                    if (wgt_acc[idx] == 0) begin
                        r.node_velocity = sat32(s);
                        r.weight_was_zero = 1'b1;
                    end else begin
                        mag = (s < 0) ? longint'(-s) : longint'(s);
                        q = (mag * 65536) / wgt_acc[idx];
                        if (q > 64'd2147483648) q = 64'd2147483648;
                        r.node_velocity = sat32((s < 0) ? -longint'(q) : longint'(q));
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Check result beats, then record the expectation of any accepted beat
    always @(posedge i_clk) begin
        if (o_valid) begin
            if (node_result_queue.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                t_res e;
                e = node_result_queue.pop_front();
                if (o_res.node_velocity !== e.node_velocity) begin
                    $error("node_velocity exp %0d got %0d", e.node_velocity,
                           o_res.node_velocity);
                    errors++;
                end
                if (o_res.weight_was_zero !== e.weight_was_zero) begin
                    $error("weight_was_zero exp %0d got %0d", e.weight_was_zero,
                           o_res.weight_was_zero);
                    errors++;
                end
                if (o_res.done_res !== e.done_res) begin
                    $error("done_res exp %0d got %0d", e.done_res, o_res.done_res);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            node_result_queue.push_back(grid_step(i_cmd));
            beat_taken = 1;
        end
    end

    // Feed command beats with random idle bursts
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || beat_taken)) begin
            beat_taken = 0;
            if (gap > 0) begin
                gap--;
                start <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                i_cmd <= cmd_queue.pop_front();
                start <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic write_axis(input logic [1:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_AXIS;
        pwdata <= {30'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        axis_reg = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (cmd_queue.size() == 0 && node_result_queue.size() == 0 && !start);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_cmd make_cmd(input logic [1:0] op, input int px, input int py,
                                      input int pz, input int v, input int ni,
                                      input int nj, input int nk);
        t_cmd c;
        c.operation = op;
        c.pos_x = px[23:0];
        c.pos_y = py[23:0];
        c.pos_z = pz[23:0];
        c.particle_velocity = v;
        c.node_i = ni[4:0];
        c.node_j = nj[4:0];
        c.node_k = nk[4:0];
        return c;
    endfunction

    function automatic int rand_pos();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return int'($urandom_range(0, 19 * 65536)) - 65536;
    endfunction

    function automatic int rand_vel();
        if ($urandom_range(0, 2) == 0) return $urandom();
        return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endfunction

    function automatic t_cmd rand_cmd();
        int sel, hi;
        sel = $urandom_range(0, 99);
        hi = ($urandom_range(0, 7) == 0) ? 31 : 16;
        if (sel < 60)
            return make_cmd(OP_SPLAT, rand_pos(), rand_pos(), rand_pos(), rand_vel(),
                            $urandom(), $urandom(), $urandom());
        if (sel < 97)
            return make_cmd(OP_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom_range(0, hi), $urandom_range(0, hi),
                            $urandom_range(0, hi));
        if (sel < 99)
            return make_cmd(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
        return make_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
    endfunction

    // Main sequence: reset, directed beats, then random phases per axis
    initial begin
        logic [1:0] axes [4];
        int ph, n;
        axes = '{AX_X, AX_Y, AX_Z, 2'd3};
        for (n = 0; n < NODES; n++) begin
            vel_acc[n] = 0;
            wgt_acc[n] = 0;
        end
        axis_reg = AX_X;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (!busy);
        repeat (10) @(posedge i_clk);
        for (ph = 0; ph < 4; ph++) begin
            write_axis(axes[ph]);
            if (ph == 0) begin
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, 32768, 32768, 32768,
                                             32'h8000_0000, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF,
                                             65536, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, -8388608, -8388608, -8388608,
                                             -65536, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, 16 * 65536, 16 * 65536, 16 * 65536,
                                             3 * 65536, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_SPLAT, 5 * 65536 + 12345, 7 * 65536 + 999,
                                             3 * 65536 + 40000, -123456, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 1, 0, 0));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 16, 15, 15));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 16, 16, 16));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 31, 31, 31));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 5, 7, 3));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 5, 6, 2));
                cmd_queue.push_back(make_cmd(OP_NONE, -1, -1, -1, -1, 31, 31, 31));
                cmd_queue.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
                cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
            end
            for (n = 0; n < 425; n++) begin
                if (ph == 3 && n == 275) begin
                    wait (cmd_queue.size() == 0);
                    quiet = 1;
                end
                cmd_queue.push_back(rand_cmd());
            end
            wait_drained();
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/p2g_pkg.sv
rtl/p2g_mul.sv
rtl/p2g_div.sv
rtl/particle_to_grid_velocity_splat.sv
tb/tb_particle_to_grid_velocity_splat.sv
